### hdl/gwvd_pkg.sv
// gwvd_pkg: shared types, register codes and datapath step functions
// for the gravity well vertex deformer. No dependencies.
`default_nettype none

package gwvd_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned RadiusW     = 31;
  localparam int unsigned CfgIdxW     = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CENTER_Z      = 3'd2,
    REG_WELL_RADIUS   = 3'd3,
    REG_PULL_STRENGTH = 3'd4,
    REG_GAIN_X        = 3'd5,
    REG_GAIN_Y        = 3'd6,
    REG_GAIN_Z        = 3'd7
  } cfg_reg_e;

  // input word
  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } vtx_in_t;

  // output word
  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     was_displaced;
    logic                     saturated;
  } vtx_out_t;

  // register file contents
  typedef struct packed {
    logic signed [CoordW-1:0]  center_x;
    logic signed [CoordW-1:0]  center_y;
    logic signed [CoordW-1:0]  center_z;
    logic        [RadiusW-1:0] well_radius;
    logic signed [CoordW-1:0]  pull_strength;
    logic signed [CoordW-1:0]  gain_x;
    logic signed [CoordW-1:0]  gain_y;
    logic signed [CoordW-1:0]  gain_z;
  } cfg_t;

  // square root state: remainder, partial root, radicand bits still to go
  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sqrt_st_t;

  // divider state: partial remainder, dividend bits shifting out, quotient in
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_st_t;

  // one result bit of the digit-by-digit integer square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t    n;
    logic [35:0] rn;
    logic [35:0] trial;
    rn    = {s.rem[33:0], s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[61:0], 2'b00};
    if (rn >= trial) begin
      n.rem  = rn - trial;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = rn;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of restoring division by a 31-bit divisor
  function automatic div_st_t div_step(div_st_t s, logic [RadiusW-1:0] d);
    div_st_t     n;
    logic [32:0] t;
    t = {s.rem, s.quo[31]};
    if (t >= {2'b00, d}) begin
      n.rem = 32'(t - {2'b00, d});
      n.quo = {s.quo[30:0], 1'b1};
    end else begin
      n.rem = t[31:0];
      n.quo = {s.quo[30:0], 1'b0};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hdl/gwvd_in_if.sv
// gwvd_in_if: valid/ready channel carrying one input vertex word.
// Depends on gwvd_pkg for the payload type.
`default_nettype none

interface gwvd_in_if;
  logic              valid;
  logic              ready;
  gwvd_pkg::vtx_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/gwvd_out_if.sv
// gwvd_out_if: valid/ready channel carrying one deformed vertex word.
// Depends on gwvd_pkg for the payload type.
`default_nettype none

interface gwvd_out_if;
  logic               valid;
  logic               ready;
  gwvd_pkg::vtx_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/gwvd_cfg_regs.sv
// gwvd_cfg_regs: configuration register file with write-only port.
// Depends on gwvd_pkg for register codes and the cfg_t struct.
`default_nettype none

module gwvd_cfg_regs #(
  parameter int unsigned FRAC_BITS = gwvd_pkg::FracBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [gwvd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gwvd_pkg::CoordW-1:0]    cfg_data_i,
  output gwvd_pkg::cfg_t                      cfg_o
);

  localparam logic [gwvd_pkg::CoordW-1:0] One = gwvd_pkg::CoordW'(1) << FRAC_BITS;

  gwvd_pkg::cfg_t cfg_q;

  // register writes; every 3-bit code selects a register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x      <= '0;
      cfg_q.center_y      <= '0;
      cfg_q.center_z      <= '0;
      cfg_q.well_radius   <= One[gwvd_pkg::RadiusW-1:0];
      cfg_q.pull_strength <= One;
      cfg_q.gain_x        <= One;
      cfg_q.gain_y        <= One;
      cfg_q.gain_z        <= One;
    end else if (cfg_we_i) begin
      case (gwvd_pkg::cfg_reg_e'(cfg_idx_i))
        gwvd_pkg::REG_CENTER_X:      cfg_q.center_x      <= cfg_data_i;
        gwvd_pkg::REG_CENTER_Y:      cfg_q.center_y      <= cfg_data_i;
        gwvd_pkg::REG_CENTER_Z:      cfg_q.center_z      <= cfg_data_i;
        gwvd_pkg::REG_WELL_RADIUS:   cfg_q.well_radius   <= cfg_data_i[gwvd_pkg::RadiusW-1:0];
        gwvd_pkg::REG_PULL_STRENGTH: cfg_q.pull_strength <= cfg_data_i;
        gwvd_pkg::REG_GAIN_X:        cfg_q.gain_x        <= cfg_data_i;
        gwvd_pkg::REG_GAIN_Y:        cfg_q.gain_y        <= cfg_data_i;
        gwvd_pkg::REG_GAIN_Z:        cfg_q.gain_z        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/gravity_well_vertex_deformer_core.sv
// gravity_well_vertex_deformer_core: radial attractor deformer, one vertex per word.
// Depends on gwvd_pkg, gwvd_in_if, gwvd_out_if and gwvd_cfg_regs.
//
// Takes one vertex word per clock while the output is not stalled and returns it deformed
// toward the well center. The depth comes from a fully pipelined datapath: a 16-stage
// square root for the distance, a radix-4 divider for the falloff weight (up to two
// quotient bits per stage) and three 16-stage dividers for the unit vector, with a single
// multiplier level per stage elsewhere. All stages move together; the input is ready
// whenever the output register is empty or being taken. Configuration registers are
// read live by the stages that use them, so write them only while the pipe is empty.
`default_nettype none

module gravity_well_vertex_deformer_core #(
  parameter int unsigned FRAC_BITS = gwvd_pkg::FracBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [gwvd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [gwvd_pkg::CoordW-1:0]  cfg_data_i,
  gwvd_in_if.sink                           vtx_i,
  gwvd_out_if.source                        vtx_o
);

  localparam int unsigned F        = FRAC_BITS;
  localparam int unsigned WW       = F + 1;
  localparam int unsigned WSteps   = F + 1;
  localparam int unsigned WStages  = (WSteps + 1) / 2;
  localparam int unsigned SqStages = 16;
  localparam int unsigned QStages  = 16;
  localparam int unsigned EpsRaw   = ((1 << F) + 500) / 1000;
  localparam int unsigned Eps      = (EpsRaw == 0) ? 1 : EpsRaw;
  localparam logic [63:0] Eps2     = 64'(Eps * Eps);

  // per-vertex data carried down the pipe
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][30:0] vmag;
    logic [2:0]       vneg;
  } side_t;

  typedef struct packed {
    logic        in_rng;
    logic        mneg;
    logic [30:0] dlen;
    side_t       side;
  } tag_t;

  gwvd_pkg::cfg_t cfg;

  gwvd_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic [30:0] rad;
  assign rad = cfg.well_radius;

  // global advance: whole pipe moves unless a finished word is stuck at the output
  logic out_vld_q;
  logic adv;
  assign adv         = !out_vld_q || vtx_o.ready;
  assign vtx_i.ready = adv;

  // stage a: center minus position, magnitude, far-axis check
  logic             a_vld_q;
  side_t            a_side_q;
  logic             a_far_q;
  side_t            a_side_d;
  logic             a_far_d;
  logic [2:0][31:0] a_pos;
  logic [2:0][31:0] a_cen;

  assign a_pos = {vtx_i.data.pos_z, vtx_i.data.pos_y, vtx_i.data.pos_x};
  assign a_cen = {cfg.center_z, cfg.center_y, cfg.center_x};

  always_comb begin
    logic [32:0] diff;
    logic [32:0] mag;
    a_far_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff = {a_cen[i][31], a_cen[i]} - {a_pos[i][31], a_pos[i]};
      mag  = diff[32] ? (33'd0 - diff) : diff;
      a_side_d.pos[i]  = a_pos[i];
      a_side_d.vneg[i] = diff[32];
      a_side_d.vmag[i] = mag[30:0];
      if (mag > {2'b00, rad}) begin
        a_far_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= vtx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q <= a_side_d;
      a_far_q  <= a_far_d;
    end
  end

  // stage b: squares of the axis distances and of the radius
  logic             b_vld_q;
  side_t            b_side_q;
  logic             b_far_q;
  logic [2:0][61:0] b_sq_q;
  logic [61:0]      b_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_side_q <= a_side_q;
      b_far_q  <= a_far_q;
      for (int i = 0; i < 3; i++) begin
        b_sq_q[i] <= 62'(a_side_q.vmag[i]) * 62'(a_side_q.vmag[i]);
      end
      b_r2_q <= 62'(rad) * 62'(rad);
    end
  end

  // stage c: squared length, range test, square root seed
  logic                 sq_vld_q [SqStages+1];
  tag_t                 sq_tag_q [SqStages+1];
  gwvd_pkg::sqrt_st_t   sq_st_q  [SqStages+1];
  logic [63:0]          c_d2;
  logic                 c_in;
  tag_t                 c_tag;
  gwvd_pkg::sqrt_st_t   c_st;

  always_comb begin
    c_d2 = 64'(b_sq_q[0]) + 64'(b_sq_q[1]) + 64'(b_sq_q[2]);
    c_in = !b_far_q && (c_d2 >= Eps2) && (c_d2 <= 64'(b_r2_q));
    c_tag.in_rng = c_in;
    c_tag.mneg   = 1'b0;
    c_tag.dlen   = '0;
    c_tag.side   = b_side_q;
    c_st.rem     = '0;
    c_st.root    = '0;
    c_st.rad     = c_d2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_tag_q[0] <= c_tag;
      sq_st_q[0]  <= c_st;
    end
  end

  // square root pipe, two root bits per stage
  for (genvar k = 1; k <= SqStages; k++) begin : g_sqrt
    gwvd_pkg::sqrt_st_t st_d;

    assign st_d = gwvd_pkg::sqrt_step(gwvd_pkg::sqrt_step(sq_st_q[k-1]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_tag_q[k] <= sq_tag_q[k-1];
        sq_st_q[k]  <= st_d;
      end
    end
  end

  // weight division seed: remainder starts at radius minus distance
  logic          w_vld_q [WStages+1];
  tag_t          w_tag_q [WStages+1];
  logic [31:0]   w_rem_q [WStages+1];
  logic [WW-1:0] w_quo_q [WStages+1];
  tag_t          w0_tag;

  always_comb begin
    w0_tag      = sq_tag_q[SqStages];
    w0_tag.dlen = sq_st_q[SqStages].root[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q[0] <= 1'b0;
    end else if (adv) begin
      w_vld_q[0] <= sq_vld_q[SqStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_tag_q[0] <= w0_tag;
      w_rem_q[0] <= {1'b0, rad} - {1'b0, sq_st_q[SqStages].root[30:0]};
      w_quo_q[0] <= '0;
    end
  end

  // weight division pipe, ((r - d) << F) / r, up to two quotient bits per stage
  for (genvar k = 1; k <= WStages; k++) begin : g_wdiv
    logic [31:0]   rem_d;
    logic [WW-1:0] quo_d;

    always_comb begin
      logic [32:0] t;
      rem_d = w_rem_q[k-1];
      quo_d = w_quo_q[k-1];
      for (int s = 0; s < 2; s++) begin
        if (2 * (k - 1) + s < WSteps) begin
          t = (2 * (k - 1) + s == 0) ? {1'b0, rem_d} : {rem_d, 1'b0};
          if (t >= {2'b00, rad}) begin
            rem_d = 32'(t - {2'b00, rad});
            quo_d = {quo_d[WW-2:0], 1'b1};
          end else begin
            rem_d = t[31:0];
            quo_d = {quo_d[WW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        w_vld_q[k] <= 1'b0;
      end else if (adv) begin
        w_vld_q[k] <= w_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        w_tag_q[k] <= w_tag_q[k-1];
        w_rem_q[k] <= rem_d;
        w_quo_q[k] <= quo_d;
      end
    end
  end

  // falloff squared
  logic            m1_vld_q;
  tag_t            m1_tag_q;
  logic [WW-1:0]   m1_w2_q;
  logic [2*WW-1:0] m1_wp;

  assign m1_wp = (2*WW)'(w_quo_q[WStages]) * (2*WW)'(w_quo_q[WStages]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= w_vld_q[WStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_tag_q <= w_tag_q[WStages];
      m1_w2_q  <= WW'(m1_wp >> F);
    end
  end

  // strength times falloff
  logic             m2_vld_q;
  tag_t             m2_tag_q;
  logic [31:0]      m2_m_q;
  logic [31:0]      m2_smag;
  logic [32+WW-1:0] m2_prod;
  tag_t             m2_tag;

  assign m2_smag = cfg.pull_strength[31] ? (32'd0 - cfg.pull_strength) : cfg.pull_strength;
  assign m2_prod = (32+WW)'(m2_smag) * (32+WW)'(m1_w2_q);

  always_comb begin
    m2_tag      = m1_tag_q;
    m2_tag.mneg = cfg.pull_strength[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (adv) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_tag_q <= m2_tag;
      m2_m_q   <= 32'(m2_prod >> F);
    end
  end

  // per-axis numerator |v| * m, seeds the unit-vector dividers
  logic              q_vld_q [QStages+1];
  tag_t              q_tag_q [QStages+1];
  gwvd_pkg::div_st_t q_st_q  [QStages+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q[0] <= 1'b0;
    end else if (adv) begin
      q_vld_q[0] <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [62:0] p;
    if (adv) begin
      q_tag_q[0] <= m2_tag_q;
      for (int i = 0; i < 3; i++) begin
        p = 63'(m2_tag_q.side.vmag[i]) * 63'(m2_m_q);
        q_st_q[0][i].rem <= {1'b0, p[62:32]};
        q_st_q[0][i].quo <= p[31:0];
      end
    end
  end

  // unit-vector dividers, two quotient bits per stage on each axis
  for (genvar k = 1; k <= QStages; k++) begin : g_qdiv
    gwvd_pkg::div_st_t st_d [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        st_d[i] = gwvd_pkg::div_step(
                    gwvd_pkg::div_step(q_st_q[k-1][i], q_tag_q[k-1].dlen),
                    q_tag_q[k-1].dlen);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        q_vld_q[k] <= 1'b0;
      end else if (adv) begin
        q_vld_q[k] <= q_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        q_tag_q[k] <= q_tag_q[k-1];
        for (int i = 0; i < 3; i++) begin
          q_st_q[k][i] <= st_d[i];
        end
      end
    end
  end

  // per-axis gain product and result sign
  logic             g_vld_q;
  tag_t             g_tag_q;
  logic [2:0][63:0] g_prod_q;
  logic [2:0]       g_neg_q;
  logic [2:0][31:0] g_gain;

  assign g_gain = {cfg.gain_z, cfg.gain_y, cfg.gain_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (adv) begin
      g_vld_q <= q_vld_q[QStages];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] gmag;
    if (adv) begin
      g_tag_q <= q_tag_q[QStages];
      for (int i = 0; i < 3; i++) begin
        gmag = g_gain[i][31] ? (32'd0 - g_gain[i]) : g_gain[i];
        g_prod_q[i] <= 64'(q_st_q[QStages][i].quo) * 64'(gmag);
        g_neg_q[i]  <= q_tag_q[QStages].side.vneg[i] ^ q_tag_q[QStages].mneg ^ g_gain[i][31];
      end
    end
  end

  // scale back and apply sign
  logic             h_vld_q;
  tag_t             h_tag_q;
  logic [2:0][63:0] h_disp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (adv) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [63:0] dm;
    if (adv) begin
      h_tag_q <= g_tag_q;
      for (int i = 0; i < 3; i++) begin
        dm = g_prod_q[i] >> F;
        h_disp_q[i] <= g_neg_q[i] ? (64'd0 - dm) : dm;
      end
    end
  end

  // add displacement, saturate, or pass the vertex through
  gwvd_pkg::vtx_out_t out_q;
  gwvd_pkg::vtx_out_t out_d;

  always_comb begin
    logic [63:0]      sum;
    logic [2:0][31:0] res;
    logic             clamp;
    clamp = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = {{32{h_tag_q.side.pos[i][31]}}, h_tag_q.side.pos[i]} + h_disp_q[i];
      if (!h_tag_q.in_rng) begin
        res[i] = h_tag_q.side.pos[i];
      end else if (sum[63:31] != {33{sum[63]}}) begin
        res[i] = sum[63] ? 32'h8000_0000 : 32'h7fff_ffff;
        clamp  = 1'b1;
      end else begin
        res[i] = sum[31:0];
      end
    end
    out_d.out_x         = res[0];
    out_d.out_y         = res[1];
    out_d.out_z         = res[2];
    out_d.was_displaced = h_tag_q.in_rng;
    out_d.saturated     = clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign vtx_o.valid = out_vld_q;
  assign vtx_o.data  = out_q;

endmodule

`default_nettype wire
